// ===== rtl/mau_pkg.sv =====
// Package for the modular arithmetic unit: operation codes, payload structs and
// controller/datapath command and status types. No dependencies.
`default_nettype none
package mau_pkg;
   localparam int unsigned OperandABits = 64;
   localparam int unsigned FieldBits = 31;
   localparam logic [FieldBits-1:0] ModulusReset = 31'd1000000007;

   typedef enum logic [3:0] {
      OP_REDUCE  = 4'd0,
      OP_ADD     = 4'd1,
      OP_SUB     = 4'd2,
      OP_MUL     = 4'd3,
      OP_DIV     = 4'd4,
      OP_POW     = 4'd5,
      OP_NEG     = 4'd6,
      OP_INVERSE = 4'd7,
      OP_EQUAL   = 4'd8
   } op_type;

   typedef struct packed {
      logic [3:0]              kind;
      logic [OperandABits-1:0] operand_a;
      logic [FieldBits-1:0]    operand_b;
   } req_type;

   typedef struct packed {
      logic [FieldBits-1:0] result;
      logic                 equal;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;       // capture request, start reduction of a and b
      logic red_step;   // one restoring-division step of the reduction
      logic simple;     // form the result of a one-step operation
      logic pow_init;   // set up the exponentiation loop
      logic mul_start;  // start a modular multiply
      logic mul_step;   // one step of the modular multiply
      logic mul_done;   // write back the multiply result
      logic exp_shift;  // drop the consumed exponent bit
      logic final_mul;  // set up the final multiply for multiply and divide
      logic res_acc;    // take the accumulator as the result
      logic res_mul;    // take the final product as the result
   } cmd_type;

   typedef struct packed {
      logic       red_last;
      logic       mul_last;
      logic       exp_zero;
      logic       exp_bit;
      logic       sq;
      logic [3:0] kind;
   } sts_type;
endpackage
`default_nettype wire

// ===== rtl/modular_arithmetic_unit_core.sv =====
// Top level of the modular arithmetic unit: modulus register, controller and
// datapath. Uses mau_pkg, mau_control, mau_datapath and mau_result.
//
// The request channel (req_valid, req_ready, req_data) carries an operation
// kind and two operands; the response channel (rsp_valid, rsp_ready, rsp_data)
// returns one reduced result per request. The modulus is written through
// csr_write_enable and csr_write_data and must only change while idle.
// One item is worked on at a time. Both operands are reduced by a restoring
// divider. Simple operations pass through the reduction, dispatch and done
// states before rsp_valid rises, and req_ready rises in the same cycle.
// Multiply adds one bit-serial modular multiply.
// Power, divide and inverse run square-and-multiply: each exponent bit costs
// a square, preceded by a multiply into the accumulator when the bit is set,
// and divide adds a final multiply. The shared bit-serial multiplier does all.
// A finished result waits in an output register while the receiver stalls;
// the next request may be taken and worked on meanwhile, but its result waits
// inside and no further request is taken until the register is free.
// Reset (synchronous) empties the output and sets the modulus to 1000000007.
`default_nettype none
module modular_arithmetic_unit_core
   import mau_pkg::*;
#(
   parameter int unsigned MODULUS_BITS = 31
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire req_type                 req_data,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output rsp_type                      rsp_data,
   input  wire logic                    csr_write_enable,
   input  wire logic [FieldBits-1:0]    csr_write_data
);
   logic [MODULUS_BITS-1:0] modulus_ff;
   cmd_type cmd;
   sts_type sts;
   logic    acc_write;
   rsp_type dp_rsp;

   always_ff @(posedge clock) begin
      if (reset) modulus_ff <= ModulusReset[MODULUS_BITS-1:0];
      else if (csr_write_enable) modulus_ff <= csr_write_data[MODULUS_BITS-1:0];
   end

   mau_control u_control (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .sts, .cmd, .acc_write
   );

   mau_datapath #(.MODULUS_BITS(MODULUS_BITS)) u_datapath (
      .clock, .modulus(modulus_ff), .req(req_data), .cmd, .sts, .rsp_data(dp_rsp)
   );

   mau_result u_result (
      .clock, .load(acc_write), .dp_rsp, .rsp_data
   );
endmodule
`default_nettype wire

// ===== rtl/mau_datapath.sv =====
// Datapath of the modular arithmetic unit: operand reduction, one-step operations
// and a bit-serial modular multiplier for multiply and exponentiation. Uses mau_pkg.
`default_nettype none
module mau_datapath
   import mau_pkg::*;
#(
   parameter int unsigned MODULUS_BITS = 31
) (
   input  wire logic                    clock,
   input  wire logic [MODULUS_BITS-1:0] modulus,
   input  wire req_type                 req,
   input  wire cmd_type                 cmd,
   output sts_type                      sts,
   output rsp_type                      rsp_data
);
   localparam int unsigned MB = MODULUS_BITS;
   localparam int unsigned CW = $clog2(OperandABits + 1);

   logic [MB-1:0]           m_eff;
   logic [OperandABits-1:0] quot_ff, quot_in;
   logic [MB-1:0]           rema_ff, rema_in, remb_ff, remb_in;
   logic [FieldBits-1:0]    braw_ff, braw_in;
   logic [3:0]              kind_ff, kind_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic [MB-1:0]           acc_ff, acc_in, base_ff, base_in;
   logic [FieldBits-1:0]    exp_ff, exp_in;
   logic [MB-1:0]           mx_ff, mx_in, my_ff, my_in, mp_ff, mp_in;
   logic                    sq_ff, sq_in;
   logic [5:0]              mcnt_ff, mcnt_in;
   rsp_type                 rsp_ff, rsp_in;
   logic [MB:0]             ra_sh, rb_sh, sum, dbl, pa, inc;
   logic [MB-1:0]           ra_nx, rb_nx, dbl_r, pa_r;
   logic                    ra_bit, rb_bit;

   assign m_eff = (modulus == '0) ? MB'(1) : modulus;

   always_comb begin
      ra_bit = quot_ff[~cnt_ff[5:0]];
      rb_bit = (cnt_ff >= CW'(OperandABits - FieldBits)) ? braw_ff[~cnt_ff[4:0]] : 1'b0;
      ra_sh = {rema_ff, ra_bit};
      rb_sh = {remb_ff, rb_bit};
      ra_nx = (ra_sh >= {1'b0, m_eff}) ? MB'(ra_sh - {1'b0, m_eff}) : ra_sh[MB-1:0];
      rb_nx = (rb_sh >= {1'b0, m_eff}) ? MB'(rb_sh - {1'b0, m_eff}) : rb_sh[MB-1:0];
      // Double-and-add modular multiply, one multiplier bit per step.
      dbl = {mp_ff, 1'b0};
      dbl_r = (dbl >= {1'b0, m_eff}) ? MB'(dbl - {1'b0, m_eff}) : dbl[MB-1:0];
      pa = {1'b0, dbl_r} + {1'b0, mx_ff};
      pa_r = (pa >= {1'b0, m_eff}) ? MB'(pa - {1'b0, m_eff}) : pa[MB-1:0];
      sum = {1'b0, rema_ff} + {1'b0, remb_ff};
      inc = {1'b0, rema_ff} + {1'b0, m_eff} - {1'b0, remb_ff};
   end

   always_comb begin
      quot_in = quot_ff; rema_in = rema_ff; remb_in = remb_ff; braw_in = braw_ff;
      kind_in = kind_ff; cnt_in = cnt_ff; acc_in = acc_ff; base_in = base_ff;
      exp_in = exp_ff; mx_in = mx_ff; my_in = my_ff; mp_in = mp_ff; sq_in = sq_ff;
      mcnt_in = mcnt_ff; rsp_in = rsp_ff;
      if (cmd.load) begin
         quot_in = req.operand_a; braw_in = req.operand_b; kind_in = req.kind;
         rema_in = '0; remb_in = '0; cnt_in = '0;
      end
      if (cmd.red_step) begin
         rema_in = ra_nx; remb_in = rb_nx; cnt_in = cnt_ff + CW'(1);
      end
      if (cmd.simple) begin
         rsp_in = '0;
         case (op_type'(kind_ff))
            OP_REDUCE: rsp_in.result = FieldBits'(rema_ff);
            OP_ADD:    rsp_in.result = FieldBits'((sum >= {1'b0, m_eff})
                                        ? MB'(sum - {1'b0, m_eff}) : sum[MB-1:0]);
            OP_SUB:    rsp_in.result = FieldBits'((inc >= {1'b0, m_eff})
                                        ? MB'(inc - {1'b0, m_eff}) : inc[MB-1:0]);
            OP_NEG:    rsp_in.result = FieldBits'((rema_ff == '0) ? MB'(0)
                                        : MB'(m_eff - rema_ff));
            OP_EQUAL:  rsp_in.equal = (rema_ff == remb_ff);
            default:   rsp_in = '0;
         endcase
      end
      if (cmd.pow_init) begin
         acc_in = (m_eff == MB'(1)) ? '0 : MB'(1);
         case (op_type'(kind_ff))
            OP_POW:     begin base_in = rema_ff; exp_in = braw_ff; end
            OP_DIV:     begin base_in = remb_ff;
                        exp_in = (m_eff < MB'(2) || remb_ff == '0) ? '0
                               : FieldBits'(m_eff - MB'(2)); end
            OP_INVERSE: begin base_in = rema_ff;
                        exp_in = (m_eff < MB'(2) || rema_ff == '0) ? '0
                               : FieldBits'(m_eff - MB'(2)); end
            default:    begin base_in = rema_ff; exp_in = '0; end
         endcase
         if (op_type'(kind_ff) == OP_DIV && (remb_ff == '0 || m_eff < MB'(2)))
            acc_in = '0;
         if (op_type'(kind_ff) == OP_INVERSE && (rema_ff == '0 || m_eff < MB'(2)))
            acc_in = '0;
      end
      if (cmd.mul_start) begin
         // sq selects squaring of the base, otherwise acc times base.
         sq_in = ~exp_ff[0];
         mx_in = exp_ff[0] ? acc_ff : base_ff;
         my_in = base_ff;
         mp_in = '0; mcnt_in = '0;
      end
      if (cmd.final_mul) begin
         sq_in = 1'b0; mx_in = rema_ff;
         my_in = (op_type'(kind_ff) == OP_MUL) ? remb_ff : acc_ff;
         mp_in = '0; mcnt_in = '0;
      end
      if (cmd.mul_step) begin
         mp_in = my_ff[MB-1] ? pa_r : dbl_r;
         my_in = {my_ff[MB-2:0], 1'b0};
         mcnt_in = mcnt_ff + 6'd1;
      end
      if (cmd.mul_done) begin
         if (sq_ff) base_in = mp_ff;
         else begin
            acc_in = mp_ff;
            // After acc update the square for this bit follows.
            mx_in = base_ff; my_in = base_ff; mp_in = '0; mcnt_in = '0; sq_in = 1'b1;
         end
      end
      if (cmd.exp_shift) exp_in = exp_ff >> 1;
      if (cmd.res_acc) rsp_in = '{result: FieldBits'(acc_ff), equal: 1'b0};
      if (cmd.res_mul) rsp_in = '{result: FieldBits'(mp_ff), equal: 1'b0};
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in; rema_ff <= rema_in; remb_ff <= remb_in; braw_ff <= braw_in;
      kind_ff <= kind_in; cnt_ff <= cnt_in; acc_ff <= acc_in; base_ff <= base_in;
      exp_ff <= exp_in; mx_ff <= mx_in; my_ff <= my_in; mp_ff <= mp_in; sq_ff <= sq_in;
      mcnt_ff <= mcnt_in; rsp_ff <= rsp_in;
   end

   assign sts = '{red_last: (cnt_ff == CW'(OperandABits - 1)),
                  mul_last: (mcnt_ff == 6'(MB - 1)),
                  exp_zero: (exp_ff == '0),
                  exp_bit:  exp_ff[0],
                  sq:       sq_ff,
                  kind:     kind_ff};
   assign rsp_data = rsp_ff;
endmodule
`default_nettype wire

// ===== rtl/mau_control.sv =====
// Controller of the modular arithmetic unit: sequences reduction, the
// square-and-multiply loop and the output handshake. Uses mau_pkg.
`default_nettype none
module mau_control
   import mau_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   input  wire sts_type sts,
   output cmd_type      cmd,
   output logic         acc_write
);
   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_RED   = 7'b0000010,
      ST_DISP  = 7'b0000100,
      ST_BIT   = 7'b0001000,
      ST_MUL   = 7'b0010000,
      ST_WB    = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      valid_ff, valid_in, fin_ff, fin_in;

   always_comb begin
      state_in = state_ff; valid_in = valid_ff; fin_in = fin_ff;
      cmd = '0; acc_write = 1'b0;
      if (valid_ff && rsp_ready) valid_in = 1'b0;
      req_ready = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: if (req_valid) begin cmd.load = 1'b1; state_in = ST_RED; end
         ST_RED: begin
            cmd.red_step = 1'b1;
            if (sts.red_last) state_in = ST_DISP;
         end
         ST_DISP: begin
            if (sts.kind == 4'(OP_MUL)) begin
               cmd.final_mul = 1'b1; fin_in = 1'b1; state_in = ST_MUL;
            end else if (sts.kind == 4'(OP_POW) || sts.kind == 4'(OP_DIV)
                         || sts.kind == 4'(OP_INVERSE)) begin
               cmd.pow_init = 1'b1; fin_in = 1'b0; state_in = ST_BIT;
            end else begin
               cmd.simple = 1'b1; state_in = ST_DONE;
            end
         end
         ST_BIT: begin
            if (sts.exp_zero) begin
               if (sts.kind == 4'(OP_DIV) && !fin_ff) begin
                  cmd.final_mul = 1'b1; fin_in = 1'b1; state_in = ST_MUL;
               end else begin
                  cmd.res_acc = 1'b1; state_in = ST_DONE;
               end
            end else begin
               cmd.mul_start = 1'b1; state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul_step = 1'b1;
            if (sts.mul_last) state_in = ST_WB;
         end
         ST_WB: begin
            if (fin_ff) begin
               cmd.res_mul = 1'b1; state_in = ST_DONE;
            end else begin
               cmd.mul_done = 1'b1;
               state_in = ST_MUL;
               if (sts.sq) begin
                  state_in = ST_BIT; cmd.exp_shift = 1'b1;
               end
            end
         end
         ST_DONE: if (!valid_ff || rsp_ready) begin
            valid_in = 1'b1; acc_write = 1'b1; state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; valid_ff <= 1'b0; fin_ff <= 1'b0;
      end else begin
         state_ff <= state_in; valid_ff <= valid_in; fin_ff <= fin_in;
      end
   end

   assign rsp_valid = valid_ff;
endmodule
`default_nettype wire

// ===== rtl/mau_result.sv =====
// Output register of the modular arithmetic unit: holds the delivered result.
// Uses mau_pkg.
`default_nettype none
module mau_result
   import mau_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    load,
   input  wire rsp_type dp_rsp,
   output rsp_type      rsp_data
);
   rsp_type hold_ff;
   always_ff @(posedge clock) begin
      if (load) hold_ff <= dp_rsp;
   end
   assign rsp_data = hold_ff;
endmodule
`default_nettype wire

// ===== rtl/modular_arithmetic_unit_checker.sv =====
// Port-level checker for the modular arithmetic unit, bound to the top level.
// Uses mau_pkg.
`default_nettype none
module modular_arithmetic_unit_checker
   import mau_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("Stalled response changed.");
   a_one: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("Second request taken while busy.");
   a_eq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.equal |-> rsp_data.result == '0)
      else $error("Equal response with non-zero result.");
   a_rst: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Response valid after reset.");
endmodule

bind modular_arithmetic_unit_core modular_arithmetic_unit_checker u_checker (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .rsp_data
);
`default_nettype wire

// ===== bench/mau_checker.sv =====
// Checker for the modular arithmetic unit: watches both channels, predicts each
// result from the request and the current modulus, and counts mismatches. Uses mau_pkg.
`timescale 1ns / 100ps
`default_nettype none
module mau_checker
   import mau_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_ready,
   input  wire req_type              req_data,
   input  wire logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire rsp_type              rsp_data,
   input  wire logic                 csr_write_enable,
   input  wire logic [FieldBits-1:0] csr_write_data,
   output int                        error_count,
   output int                        pending_count
);
   logic [FieldBits-1:0] modulus;
   rsp_type              expected_q[$];

   function automatic logic [63:0] mulmod(logic [63:0] x, logic [63:0] y, logic [63:0] m);
      return (x * y) % m;
   endfunction

   function automatic logic [63:0] powmod(logic [63:0] base, logic [63:0] e, logic [63:0] m);
      logic [63:0] acc;
      acc = 64'd1 % m;
      while (e != 0) begin
         if (e[0]) acc = mulmod(acc, base, m);
         base = mulmod(base, base, m);
         e = e >> 1;
      end
      return acc;
   endfunction

   function automatic logic [63:0] invmod(logic [63:0] x, logic [63:0] m);
      if (x == 0 || m < 2) return 0;
      return powmod(x, m - 2, m);
   endfunction

   function automatic rsp_type compute_result(req_type rq, logic [FieldBits-1:0] modv);
      logic [63:0] m, a, b, braw, r, t;
      rsp_type     rs;
      m    = (modv == 0) ? 64'd1 : {33'd0, modv};
      a    = rq.operand_a % m;
      braw = {33'd0, rq.operand_b};
      b    = braw % m;
      r    = 0;
      rs.equal = 1'b0;
      case (rq.kind)
         OP_REDUCE:  r = a;
         OP_ADD:     begin t = a + b; r = (t >= m) ? t - m : t; end
         OP_SUB:     begin t = a + m - b; r = (t >= m) ? t - m : t; end
         OP_MUL:     r = mulmod(a, b, m);
         OP_DIV:     r = mulmod(a, invmod(b, m), m);
         OP_POW:     r = powmod(a, braw, m);
         OP_NEG:     begin t = m - a; r = (t >= m) ? t - m : t; end
         OP_INVERSE: r = invmod(a, m);
         OP_EQUAL:   rs.equal = (a == b);
         default:    r = 0;
      endcase
      rs.result = r[FieldBits-1:0];
      return rs;
   endfunction

   assign pending_count = expected_q.size();

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         modulus <= ModulusReset;
         error_count <= 0;
      end else begin
         if (csr_write_enable) modulus <= csr_write_data;
         if (req_valid && req_ready) expected_q.push_back(compute_result(req_data, modulus));
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $error("unexpected transfer: result %0d equal %0d", rsp_data.result,
                      rsp_data.equal);
               error_count <= error_count + 1;
            end else begin
               want = expected_q.pop_front();
               if (want.result !== rsp_data.result) begin
                  $error("result: expected %0d, actual %0d", want.result, rsp_data.result);
                  error_count <= error_count + 1;
               end else if (want.equal !== rsp_data.equal) begin
                  $error("equal: expected %0d, actual %0d", want.equal, rsp_data.equal);
                  error_count <= error_count + 1;
               end
            end
         end
      end
   end
endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
// Top of the testbench for modular_arithmetic_unit_core: clock, reset, stimulus,
// modulus writes and the verdict. Uses mau_pkg and mau_checker.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
   import mau_pkg::*;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_write_enable = 1'b0;
   logic [FieldBits-1:0] csr_write_data = '0;
   int                   error_count;
   int                   pending_count;
   bit                   quiet_phase = 1'b0;
   bit                   long_hold = 1'b0;

   logic [FieldBits-1:0] modulus_set[6] = '{31'd1000000007, 31'd2147483647, 31'd2,
                                            31'd13, 31'd0, 31'd1};

   always #4 clock = ~clock;

   modular_arithmetic_unit_core #(.MODULUS_BITS(31)) u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   mau_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .error_count(error_count), .pending_count(pending_count)
   );

   initial begin
      #200_000_000;
      $display("tb_top failed");
      $finish;
   end

   // The receiver stalls in bursts, and once holds off for a long stretch.
   initial begin
      int n;
      @(negedge clock);
      while (!reset) @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (long_hold) begin
            rsp_ready <= 1'b0;
            repeat (3000) @(negedge clock);
            long_hold = 1'b0;
         end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            n = $urandom_range(1, 19);
            repeat (n) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
            n = $urandom_range(1, 30);
            repeat (n) @(negedge clock);
         end
      end
   end

   task automatic send(req_type item);
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      if (!quiet_phase && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
   endtask

   task automatic drain_and_idle();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (2200) @(negedge clock);
   endtask

   task automatic write_modulus(logic [FieldBits-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic req_type random_item(logic [FieldBits-1:0] modv);
      req_type it;
      it.kind = $urandom_range(0, 15) < 14 ? 4'($urandom_range(0, 8)) : 4'($urandom_range(9, 15));
      case ($urandom_range(0, 3))
         0: it.operand_a = {$urandom, $urandom};
         1: it.operand_a = 64'($urandom_range(0, 3)) * 64'(modv) + 64'($urandom_range(0, 2));
         2: it.operand_a = 64'(modv) - 64'($urandom_range(0, 2));
         default: it.operand_a = 64'($urandom) % (64'(modv) + 64'd1);
      endcase
      case ($urandom_range(0, 3))
         0: it.operand_b = 31'($urandom);
         1: it.operand_b = 31'($urandom_range(0, 3));
         2: it.operand_b = modv - 31'($urandom_range(0, 1));
         default: it.operand_b = it.operand_a[30:0];
      endcase
      return it;
   endfunction

   initial begin
      req_type it;
      int      phase;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int k = 0; k <= 8; k++) begin
         send('{kind: 4'(k), operand_a: '1, operand_b: '1});
         send('{kind: 4'(k), operand_a: 64'd0, operand_b: 31'd0});
      end
      send('{kind: OP_POW, operand_a: 64'd0, operand_b: 31'd0});
      send('{kind: OP_POW, operand_a: 64'd12345, operand_b: 31'd0});
      send('{kind: OP_INVERSE, operand_a: 64'd1000000007, operand_b: 31'd5});
      send('{kind: OP_DIV, operand_a: 64'd77, operand_b: 31'd1000000007});
      send('{kind: 4'd15, operand_a: 64'd3, operand_b: 31'd3});
      send('{kind: OP_EQUAL, operand_a: 64'd1000000008, operand_b: 31'd1});

      for (phase = 0; phase < 8; phase++) begin
         drain_and_idle();
         if (phase < 6) write_modulus(modulus_set[phase]);
         else write_modulus(31'($urandom_range(3, 40)) | 31'd1);
         if (phase == 1) long_hold = 1'b1;
         if (phase == 7) quiet_phase = 1'b1;
         for (int i = 0; i < 250; i++) begin
            it = random_item(u_checker.modulus);
            send(it);
         end
      end

      drain_and_idle();
      if (error_count == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ===== sim.f =====
rtl/mau_pkg.sv
rtl/mau_datapath.sv
rtl/mau_control.sv
rtl/modular_arithmetic_unit_core.sv
rtl/mau_result.sv
rtl/modular_arithmetic_unit_checker.sv
bench/mau_checker.sv
bench/tb_top.sv
